// ===== rtl/core/nmea_heading_sentence_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the heading sentence parser
// Shared concurrent checks, each use on a line of its own.
// ----------------------------------------------------------------------------
`ifndef NMEA_HEADING_SENTENCE_PARSER_UNIT_ASSERT_SVH
`define NMEA_HEADING_SENTENCE_PARSER_UNIT_ASSERT_SVH

// Condition a implies condition b in the same cycle.
`define NHSP_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// Condition a implies condition b in the next cycle.
`define NHSP_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/nhsp_pkg.sv =====
// ----------------------------------------------------------------------------
// nhsp_pkg
// Types, constants and helpers shared by the heading sentence parser.
// ----------------------------------------------------------------------------
package nhsp_pkg;

  localparam int HEADING_FIELD_DEF = 14;
  localparam int MIN_FIELDS_DEF    = 15;
  localparam int POS_FLAG_FIELD    = 9;
  localparam int ATT_FLAG_FIELD    = 16;
  localparam int PREFIX_LEN        = 8;

  localparam logic [18:0] FULL_TURN_MDEG = 19'd360000;
  localparam logic [23:0] MAX_INT_DEG    = 24'd999999;

  // Configuration register indexes
  localparam logic CFG_VERIFY_SUM    = 1'b0;
  localparam logic CFG_REQUIRE_FLAGS = 1'b1;

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FRAME   = 3'd1;
  localparam logic [2:0] ST_HEX     = 3'd2;
  localparam logic [2:0] ST_SUM     = 3'd3;
  localparam logic [2:0] ST_FIELDS  = 3'd4;
  localparam logic [2:0] ST_FLAGS   = 3'd5;
  localparam logic [2:0] ST_HEADING = 3'd6;

  // Classified input item passed from front to back
  typedef struct packed {
    logic       eol;
    logic [7:0] chr;
    logic       blank;
    logic       digit;
    logic       hex_ok;
    logic [3:0] nibble;
  } char_class_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = CH_DOLLAR;
      3'd1: c = 8'h50; // P
      3'd2: c = 8'h53; // S
      3'd3: c = 8'h4F; // O
      3'd4: c = 8'h4E; // N
      3'd5: c = 8'h4E; // N
      3'd6: c = CH_UPPER_A;
      3'd7: c = 8'h56; // V
      default: c = CH_DOLLAR;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/nhsp_front.sv =====
// ----------------------------------------------------------------------------
// nhsp_front
// Classifies each accepted byte and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module nhsp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [7:0]           in_char_byte,
  input  logic                 in_end_of_line,
  output logic                 in_full,
  input  logic                 q_pop,
  output logic                 q_valid,
  output nhsp_pkg::char_class_t q_head
);
  import nhsp_pkg::*;

  char_class_t        cls;
  char_class_t        slot_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         cnt_r;
  logic               push_ok, pop_ok;
  logic [7:0]         c;
  logic               is_upper_hex, is_lower_hex;

  assign c            = in_char_byte;
  assign is_upper_hex = (c >= 8'h41) && (c <= 8'h46);
  assign is_lower_hex = (c >= 8'h61) && (c <= 8'h66);

  always_comb begin
    cls.eol    = in_end_of_line;
    cls.chr    = c;
    cls.blank  = (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
    cls.digit  = (c >= 8'h30) && (c <= 8'h39);
    cls.hex_ok = cls.digit || is_upper_hex || is_lower_hex;
    cls.nibble = cls.digit ? c[3:0] : 4'(c[3:0] + 4'd9);
  end

  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = slot_r[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= cls;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_ok) wr_ptr_r <= ~wr_ptr_r;
      if (pop_ok)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= 2'(cnt_r + {1'b0, push_ok} - {1'b0, pop_ok});
    end
  end

endmodule

// ===== rtl/core/nhsp_back.sv =====
// ----------------------------------------------------------------------------
// nhsp_back
// Runs the sentence state machine on classified items and holds the result.
// ----------------------------------------------------------------------------
module nhsp_back #(
  parameter int HEADING_FIELD = nhsp_pkg::HEADING_FIELD_DEF,
  parameter int MIN_FIELDS    = nhsp_pkg::MIN_FIELDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  nhsp_pkg::char_class_t q_head,
  output logic                  q_pop,
  input  logic                  verify_checksum,
  input  logic                  require_valid_flags,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [18:0]           out_heading_mdeg,
  output logic [2:0]            out_status
);
  import nhsp_pkg::*;

  typedef enum logic [2:0] {
    LP_BLANK, LP_PREFIX, LP_BODY, LP_CHECK, LP_REJECT
  } line_phase_t;

  typedef enum logic [2:0] {
    NP_START, NP_SIGN, NP_INT, NP_DOT_EMPTY, NP_FRAC, NP_BAD
  } num_phase_t;

  line_phase_t lp_r, lp_nxt;
  num_phase_t  np_r, np_nxt;
  logic [3:0]  pidx_r, pidx_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [4:0]  fidx_r, fidx_nxt;
  logic [1:0]  fcc_r, fcc_nxt;
  logic        pos_ok_r, pos_ok_nxt;
  logic        att_ok_r, att_ok_nxt;
  logic [19:0] ival_r, ival_nxt;
  logic [8:0]  imod_r, imod_nxt;
  logic [9:0]  fsc_r, fsc_nxt;
  logic [1:0]  fd_r, fd_nxt;
  logic        neg_r, neg_nxt;
  logic [1:0]  hseen_r, hseen_nxt;
  logic [7:0]  hval_r, hval_nxt;
  logic        hbad_r, hbad_nxt;

  logic        out_valid_r;
  logic [18:0] out_heading_r;
  logic [2:0]  out_status_r;

  logic        take, take_eol;
  logic [7:0]  c;
  logic [3:0]  d;
  logic [23:0] ival_ext;
  logic [11:0] mod_in, mod_out;
  logic [9:0]  frac_add;
  logic [18:0] total, heading_fin;
  logic [2:0]  status_fin;

  assign c        = q_head.chr;
  assign d        = q_head.chr[3:0];
  assign take     = q_valid && (!q_head.eol || !out_valid_r || out_pop);
  assign take_eol = take && q_head.eol;
  assign q_pop    = take;

  // Integer part: exact value for the range check, residue mod 360 for the result
  assign ival_ext = 24'(ival_r) * 24'd10 + 24'(d);
  assign mod_in   = 12'(imod_r) * 12'd10 + 12'(d);

  always_comb begin
    mod_out = mod_in;
    for (int k = 1; k <= 9; k++) begin
      if (mod_in >= 12'(k * 360)) mod_out = mod_in - 12'(k * 360);
    end
  end

  always_comb begin
    unique case (fd_r)
      2'd0:    frac_add = 10'(d) * 10'd100;
      2'd1:    frac_add = 10'(d) * 10'd10;
      default: frac_add = 10'(d);
    endcase
  end

  // End-of-line verdict; first failing check wins
  assign total = 19'(imod_r) * 19'd1000 + 19'(fsc_r);

  always_comb begin
    heading_fin = 19'd0;
    if (lp_r != LP_CHECK) begin
      status_fin = ST_FRAME;
    end else if (verify_checksum && hseen_r == 2'd2 && hbad_r) begin
      status_fin = ST_HEX;
    end else if (verify_checksum && hseen_r == 2'd2 && hval_r != xor_r) begin
      status_fin = ST_SUM;
    end else if (({1'b0, fidx_r} + 6'd1) < 6'(MIN_FIELDS)) begin
      status_fin = ST_FIELDS;
    end else if (require_valid_flags && !(pos_ok_r && att_ok_r)) begin
      status_fin = ST_FLAGS;
    end else if (np_r != NP_INT && np_r != NP_FRAC) begin
      status_fin = ST_HEADING;
    end else begin
      status_fin  = ST_OK;
      heading_fin = (neg_r && total != 19'd0) ? 19'(FULL_TURN_MDEG - total) : total;
    end
  end

  always_comb begin
    lp_nxt = lp_r;   np_nxt = np_r;     pidx_nxt = pidx_r;   xor_nxt = xor_r;
    fidx_nxt = fidx_r; fcc_nxt = fcc_r; pos_ok_nxt = pos_ok_r; att_ok_nxt = att_ok_r;
    ival_nxt = ival_r; imod_nxt = imod_r; fsc_nxt = fsc_r;   fd_nxt = fd_r;
    neg_nxt = neg_r; hseen_nxt = hseen_r; hval_nxt = hval_r; hbad_nxt = hbad_r;
    if (take && q_head.eol) begin
      lp_nxt = LP_BLANK;  np_nxt = NP_START; pidx_nxt = 4'd0;  xor_nxt = 8'd0;
      fidx_nxt = 5'd0;    fcc_nxt = 2'd0;    pos_ok_nxt = 1'b0; att_ok_nxt = 1'b0;
      ival_nxt = 20'd0;   imod_nxt = 9'd0;   fsc_nxt = 10'd0;  fd_nxt = 2'd0;
      neg_nxt = 1'b0;     hseen_nxt = 2'd0;  hval_nxt = 8'd0;  hbad_nxt = 1'b0;
    end else if (take) begin
      unique case (lp_r)
        LP_BLANK, LP_PREFIX: begin
          if (!(lp_r == LP_BLANK && q_head.blank)) begin
            if (c != prefix_char(pidx_r[2:0])) begin
              lp_nxt = LP_REJECT;
            end else begin
              if (pidx_r != 4'd0) xor_nxt = xor_r ^ c;
              pidx_nxt = 4'(pidx_r + 4'd1);
              lp_nxt   = (pidx_r == 4'(PREFIX_LEN - 1)) ? LP_BODY : LP_PREFIX;
            end
          end
        end
        LP_BODY: begin
          if (c == CH_STAR) begin
            lp_nxt = LP_CHECK;
          end else begin
            xor_nxt = xor_r ^ c;
            if (c == CH_COMMA) begin
              if (fidx_r != 5'd31) fidx_nxt = 5'(fidx_r + 5'd1);
              fcc_nxt = 2'd0;
            end else begin
              if (fidx_r == 5'(POS_FLAG_FIELD))
                pos_ok_nxt = (fcc_r == 2'd0) && (c == CH_UPPER_A);
              if (fidx_r == 5'(ATT_FLAG_FIELD))
                att_ok_nxt = (fcc_r == 2'd0) && (c == CH_UPPER_A);
              if (fidx_r == 5'(HEADING_FIELD)) begin
                unique case (np_r)
                  NP_START, NP_SIGN: begin
                    if (np_r == NP_START && (c == CH_PLUS || c == CH_MINUS)) begin
                      neg_nxt = (c == CH_MINUS);
                      np_nxt  = NP_SIGN;
                    end else if (q_head.digit) begin
                      ival_nxt = 20'(d);
                      imod_nxt = 9'(d);
                      np_nxt   = NP_INT;
                    end else if (c == CH_DOT) begin
                      np_nxt = NP_DOT_EMPTY;
                    end else begin
                      np_nxt = NP_BAD;
                    end
                  end
                  NP_INT: begin
                    if (q_head.digit) begin
                      ival_nxt = ival_ext[19:0];
                      imod_nxt = mod_out[8:0];
                      if (ival_ext > MAX_INT_DEG) np_nxt = NP_BAD;
                    end else if (c == CH_DOT) begin
                      np_nxt = NP_FRAC;
                    end else begin
                      np_nxt = NP_BAD;
                    end
                  end
                  NP_DOT_EMPTY, NP_FRAC: begin
                    if (q_head.digit) begin
                      if (fd_r != 2'd3) begin
                        fsc_nxt = 10'(fsc_r + frac_add);
                        fd_nxt  = 2'(fd_r + 2'd1);
                      end
                      np_nxt = NP_FRAC;
                    end else begin
                      np_nxt = NP_BAD;
                    end
                  end
                  default: np_nxt = NP_BAD;
                endcase
              end
              if (fcc_r != 2'd3) fcc_nxt = 2'(fcc_r + 2'd1);
            end
          end
        end
        LP_CHECK: begin
          if (c == CH_STAR) begin
            lp_nxt = LP_REJECT;
          end else begin
            unique case (hseen_r)
              2'd0: begin
                if (!q_head.blank) begin
                  if (!q_head.hex_ok) hbad_nxt = 1'b1;
                  else hval_nxt = {q_head.nibble, 4'd0};
                  hseen_nxt = 2'd1;
                end
              end
              2'd1: begin
                if (q_head.blank) begin
                  hseen_nxt = 2'd3;
                end else begin
                  if (!q_head.hex_ok) hbad_nxt = 1'b1;
                  else hval_nxt = {hval_r[7:4], q_head.nibble};
                  hseen_nxt = 2'd2;
                end
              end
              2'd3: begin
                if (!q_head.blank) begin
                  hbad_nxt  = 1'b1;
                  hseen_nxt = 2'd2;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r <= LP_BLANK;  np_r <= NP_START; pidx_r <= 4'd0;  xor_r <= 8'd0;
      fidx_r <= 5'd0;    fcc_r <= 2'd0;    pos_ok_r <= 1'b0; att_ok_r <= 1'b0;
      ival_r <= 20'd0;   imod_r <= 9'd0;   fsc_r <= 10'd0;  fd_r <= 2'd0;
      neg_r <= 1'b0;     hseen_r <= 2'd0;  hval_r <= 8'd0;  hbad_r <= 1'b0;
      out_valid_r   <= 1'b0;
      out_heading_r <= 19'd0;
      out_status_r  <= ST_OK;
    end else begin
      lp_r <= lp_nxt;     np_r <= np_nxt;     pidx_r <= pidx_nxt;     xor_r <= xor_nxt;
      fidx_r <= fidx_nxt; fcc_r <= fcc_nxt;   pos_ok_r <= pos_ok_nxt; att_ok_r <= att_ok_nxt;
      ival_r <= ival_nxt; imod_r <= imod_nxt; fsc_r <= fsc_nxt;       fd_r <= fd_nxt;
      neg_r <= neg_nxt;   hseen_r <= hseen_nxt; hval_r <= hval_nxt;   hbad_r <= hbad_nxt;
      if (take_eol) begin
        out_valid_r   <= 1'b1;
        out_heading_r <= heading_fin;
        out_status_r  <= status_fin;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_heading_mdeg = out_heading_r;
  assign out_status       = out_status_r;

`include "nmea_heading_sentence_parser_unit_assert.svh"

  `NHSP_ASSERT_NEXT(a_eol_gives_result, clk, rst_n, take_eol, out_valid_r)
  `NHSP_ASSERT_IMPL(a_fail_zero_heading, clk, rst_n, out_valid_r && out_status_r != ST_OK, out_heading_r == 19'd0)
  `NHSP_ASSERT_IMPL(a_heading_in_turn, clk, rst_n, out_valid_r, out_heading_r < FULL_TURN_MDEG)
  `NHSP_ASSERT_IMPL(a_body_after_prefix, clk, rst_n, lp_r == LP_BODY || lp_r == LP_CHECK, pidx_r == 4'(PREFIX_LEN))

endmodule

// ===== rtl/core/nmea_heading_sentence_parser_unit.sv =====
// ----------------------------------------------------------------------------
// nmea_heading_sentence_parser_unit
// Parses PSONNAV heading sentences byte by byte and reports status and heading.
// ----------------------------------------------------------------------------
//  channel | ports                                    | handshake
//  --------+------------------------------------------+-------------------------
//  input   | in_char_byte, in_end_of_line             | in_push / in_full
//  result  | out_heading_mdeg, out_status             | out_empty / out_pop
//  config  | cfg_index, cfg_data                      | cfg_we, no wait
//
//  One item per cycle sustained unless an unpopped result holds the queue; a result
//  shows on the out_ ports after its end-of-line item is accepted: the item is
//  registered in the classify queue, then the parser step registers the verdict.
//  Synchronous active-low reset clears the line state, queue and result register.
//  An unpopped result holds the next end-of-line item at the queue head, and the
//  items behind it; once the two-entry queue fills, in_full stalls the input.
// ----------------------------------------------------------------------------
module nmea_heading_sentence_parser_unit #(
  parameter int HEADING_FIELD = nhsp_pkg::HEADING_FIELD_DEF,
  parameter int MIN_FIELDS    = nhsp_pkg::MIN_FIELDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_line,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [18:0] out_heading_mdeg,
  output logic [2:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);
  import nhsp_pkg::*;

  char_class_t q_head;
  logic        q_valid, q_pop;
  logic        verify_r, flags_r;

  // Configuration registers: verify checksum defaults on, flag check off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verify_r <= 1'b1;
      flags_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERIFY_SUM:    verify_r <= cfg_data;
        CFG_REQUIRE_FLAGS: flags_r  <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Front: classify each byte and buffer it
  nhsp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_char_byte   (in_char_byte),
    .in_end_of_line (in_end_of_line),
    .in_full        (in_full),
    .q_pop          (q_pop),
    .q_valid        (q_valid),
    .q_head         (q_head)
  );

  // Back: advance the sentence state, hold the verdict until popped
  nhsp_back #(
    .HEADING_FIELD (HEADING_FIELD),
    .MIN_FIELDS    (MIN_FIELDS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .verify_checksum     (verify_r),
    .require_valid_flags (flags_r),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_heading_mdeg    (out_heading_mdeg),
    .out_status          (out_status)
  );

endmodule
